>>> hw/rtl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Shared sizes, codes and record types for the queue's storage, sequencer
// and top level.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCNT_W = 4;

  // Operation codes carried by the kind field.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bpq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_TOPS,
    S_DONE
  } bpq_state_e;

  typedef struct packed {
    logic        [PRIO_W-1:0] prio;
    logic signed [ELEM_W-1:0] value;
  } bpq_entry_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    bpq_entry_t           wdata;
    logic [IDX_W-1:0]     raddr;
  } bpq_mem_req_t;

  typedef struct packed {
    bpq_status_e              status;
    logic signed [ELEM_W-1:0] element;
    logic        [PRIO_W-1:0] top_prio;
    logic        [CNT_W-1:0]  count;
  } bpq_result_t;

endpackage

>>> hw/rtl/bpq_mem.sv
// ----------------------------------------------------------------------------
// Bounded priority queue entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpq_mem (
  input  logic                  clk_i,
  input  bpq_pkg::bpq_mem_req_t req_i,
  output bpq_pkg::bpq_entry_t   rdata_o
);

  bpq_pkg::bpq_entry_t mem_q [bpq_pkg::DEPTH];
  bpq_pkg::bpq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bpq_seq.sv
// ----------------------------------------------------------------------------
// Bounded priority queue sequencer
// Walks the entry store through one read port, using a single priority
// comparator to find the top entry, then closes the gap and rescans.
// ----------------------------------------------------------------------------
module bpq_seq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  kind_i,
  input  logic signed [bpq_pkg::ELEM_W-1:0]     elem_i,
  input  logic        [bpq_pkg::PRIO_W-1:0]     prio_i,
  input  logic                                  take_i,
  input  bpq_pkg::bpq_entry_t                   rdata_i,
  output bpq_pkg::bpq_mem_req_t                 mem_req_o,
  output logic                                  idle_o,
  output logic                                  done_o,
  output bpq_pkg::bpq_result_t                  res_o
);

  bpq_pkg::bpq_state_e state_q, state_d;

  logic [bpq_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [bpq_pkg::PRIO_W-1:0] top_q, top_d;
  logic [bpq_pkg::CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [bpq_pkg::IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic [bpq_pkg::IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [bpq_pkg::PRIO_W-1:0] best_prio_q, best_prio_d;
  logic signed [bpq_pkg::ELEM_W-1:0] best_val_q, best_val_d;
  logic signed [bpq_pkg::ELEM_W-1:0] elem_q, elem_d;
  bpq_pkg::bpq_status_e       status_q, status_d;

  logic                       sweeping;
  logic                       issue;
  logic                       sweep_end;
  logic [bpq_pkg::PRIO_W-1:0] cmp_a;
  logic [bpq_pkg::PRIO_W-1:0] cmp_b;
  logic                       cmp_ge;

  assign sweeping  = (state_q == bpq_pkg::S_FIND) || (state_q == bpq_pkg::S_SHIFT) ||
                     (state_q == bpq_pkg::S_TOPS);
  assign issue     = sweeping && (rd_ptr_q < cnt_q);
  assign sweep_end = !issue && !chk_vld_q;

  // The one comparator: new priority against the running top on insert,
  // stored priority against the running best during a sweep.
  assign cmp_a  = (state_q == bpq_pkg::S_IDLE) ? prio_i : rdata_i.prio;
  assign cmp_b  = (state_q == bpq_pkg::S_IDLE) ? top_q  : best_prio_q;
  assign cmp_ge = (cmp_a >= cmp_b);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bpq_pkg::S_IDLE: begin
        if (start_i) begin
          if ((kind_i == bpq_pkg::KIND_DELETE) && (cnt_q != '0)) begin
            state_d = bpq_pkg::S_FIND;
          end else begin
            state_d = bpq_pkg::S_DONE;
          end
        end
      end
      bpq_pkg::S_FIND: begin
        if (sweep_end) begin
          state_d = bpq_pkg::S_SHIFT;
        end
      end
      bpq_pkg::S_SHIFT: begin
        if (sweep_end) begin
          state_d = bpq_pkg::S_TOPS;
        end
      end
      bpq_pkg::S_TOPS: begin
        if (sweep_end) begin
          state_d = bpq_pkg::S_DONE;
        end
      end
      bpq_pkg::S_DONE: begin
        if (take_i) begin
          state_d = bpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    top_d       = top_q;
    rd_ptr_d    = rd_ptr_q;
    chk_vld_d   = issue;
    chk_idx_d   = rd_ptr_q[bpq_pkg::IDX_W-1:0];
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    best_val_d  = best_val_q;
    elem_d      = elem_q;
    status_d    = status_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = chk_idx_q - bpq_pkg::IDX_W'(1);
    mem_req_o.wdata = rdata_i;
    mem_req_o.raddr = rd_ptr_q[bpq_pkg::IDX_W-1:0];

    if (issue) begin
      rd_ptr_d = rd_ptr_q + bpq_pkg::CNT_W'(1);
    end

    case (state_q)
      bpq_pkg::S_IDLE: begin
        if (start_i) begin
          best_prio_d = '0;
          rd_ptr_d    = '0;
          elem_d      = '0;
          status_d    = bpq_pkg::ST_OK;
          if (kind_i == bpq_pkg::KIND_INSERT) begin
            if (cnt_q == bpq_pkg::CNT_W'(bpq_pkg::DEPTH)) begin
              status_d = bpq_pkg::ST_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cnt_q[bpq_pkg::IDX_W-1:0];
              mem_req_o.wdata = '{prio: prio_i, value: elem_i};
              cnt_d           = cnt_q + bpq_pkg::CNT_W'(1);
              if (cmp_ge) begin
                top_d = prio_i;
              end
            end
          end else if (cnt_q == '0) begin
            status_d = bpq_pkg::ST_EMPTY;
          end
        end
      end
      bpq_pkg::S_FIND: begin
        // Greater or equal keeps the last of equal priorities.
        if (chk_vld_q && cmp_ge) begin
          best_idx_d  = chk_idx_q;
          best_prio_d = rdata_i.prio;
          best_val_d  = rdata_i.value;
        end
        if (sweep_end) begin
          elem_d   = best_val_q;
          rd_ptr_d = bpq_pkg::CNT_W'(best_idx_q) + bpq_pkg::CNT_W'(1);
        end
      end
      bpq_pkg::S_SHIFT: begin
        if (chk_vld_q) begin
          mem_req_o.we = 1'b1;
        end
        if (sweep_end) begin
          cnt_d       = cnt_q - bpq_pkg::CNT_W'(1);
          rd_ptr_d    = '0;
          best_prio_d = '0;
        end
      end
      bpq_pkg::S_TOPS: begin
        if (chk_vld_q && cmp_ge) begin
          best_prio_d = rdata_i.prio;
        end
        if (sweep_end) begin
          top_d = best_prio_q;
        end
      end
      bpq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpq_pkg::S_IDLE;
      cnt_q     <= '0;
      top_q     <= '0;
      rd_ptr_q  <= '0;
      chk_vld_q <= 1'b0;
      status_q  <= bpq_pkg::ST_OK;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      top_q     <= top_d;
      rd_ptr_q  <= rd_ptr_d;
      chk_vld_q <= chk_vld_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_val_q  <= best_val_d;
    elem_q      <= elem_d;
  end

  assign idle_o = (state_q == bpq_pkg::S_IDLE);
  assign done_o = (state_q == bpq_pkg::S_DONE);

  assign res_o.status   = status_q;
  assign res_o.element  = elem_q;
  assign res_o.top_prio = top_q;
  assign res_o.count    = cnt_q;

endmodule

>>> hw/rtl/bounded_priority_queue_top.sv
// An insert, or any rejected word, has its result waiting in the sequencer
// in the cycle after acceptance. A delete scans the stored entries for the top one,
// moves every later entry down by one place, then rescans for the new top priority.
// One word is handled at a time; the entry store's single read port sets the delete time.
// Reset (rst_ni low, asynchronous) empties the queue, idles the sequencer and drops out_valid_o.
// The entry store itself is not cleared; only entries below the count are ever used.
// ----------------------------------------------------------------------------
// Bounded priority queue, top level
// Holds up to DEPTH (element, priority) entries in insertion order. An
// insert appends, a delete removes the highest priority entry (last among
// equals) and returns its element. Every result reports the current top
// priority and entry count.
// ----------------------------------------------------------------------------
module bounded_priority_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic signed [bpq_pkg::ELEM_W-1:0] element_in_i,
  input  logic        [bpq_pkg::PRIO_W-1:0] priority_in_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic        [bpq_pkg::STAT_W-1:0] status_o,
  output logic signed [bpq_pkg::ELEM_W-1:0] element_out_o,
  output logic        [bpq_pkg::PRIO_W-1:0] top_priority_o,
  output logic        [bpq_pkg::OCNT_W-1:0] count_o
);

  bpq_pkg::bpq_mem_req_t mem_req;
  bpq_pkg::bpq_entry_t   mem_rdata;
  bpq_pkg::bpq_result_t  res;

  logic seq_idle;
  logic seq_done;
  logic start;
  logic load;

  logic                              out_valid_q, out_valid_d;
  logic        [bpq_pkg::STAT_W-1:0] status_q;
  logic signed [bpq_pkg::ELEM_W-1:0] element_q;
  logic        [bpq_pkg::PRIO_W-1:0] top_prio_q;
  logic        [bpq_pkg::OCNT_W-1:0] count_q;

  // A word is taken whenever the sequencer is idle, even while an earlier
  // result still sits in the output register waiting for the consumer.
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;

  // The finished result moves into the output register once that register
  // is empty or being drained in this cycle; until then the sequencer holds.
  assign load        = seq_done && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  bpq_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bpq_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .kind_i    (kind_i),
    .elem_i    (element_in_i),
    .prio_i    (priority_in_i),
    .take_i    (load),
    .rdata_i   (mem_rdata),
    .mem_req_o (mem_req),
    .idle_o    (seq_idle),
    .done_o    (seq_done),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The reported count carries the full entry count; both are four bits wide.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q   <= res.status;
      element_q  <= res.element;
      top_prio_q <= res.top_prio;
      count_q    <= bpq_pkg::OCNT_W'(res.count);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign element_out_o  = element_q;
  assign top_priority_o = top_prio_q;
  assign count_o        = count_q;

  // An accepted word always keeps the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input not stalled after a word was accepted");

  // A full report only happens with the store at its depth.
  a_full_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == bpq_pkg::ST_FULL)) |->
      (count_o == bpq_pkg::OCNT_W'(bpq_pkg::DEPTH))
  ) else $error("full status with a store below its depth");

  // An empty report leaves an empty store with nothing returned.
  a_empty_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == bpq_pkg::ST_EMPTY)) |->
      ((count_o == '0) && (top_priority_o == '0) && (element_out_o == '0))
  ) else $error("empty status with a nonempty result");

  // The output register only changes when a new result is loaded.
  a_result_from_seq: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(seq_done)) |-> $stable(status_o)
  ) else $error("result changed without a finished operation");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Bounded priority queue testbench
// Sends a short scripted sequence of insert and delete words, then about five
// hundred random ones. Every result word is checked field by field against a
// typed reply or a behavioral copy of the queue. Both sides of the handshake
// stall at random, and the receiver holds off long enough to back the queue up once.
// ----------------------------------------------------------------------------
module tb_top;
  import bpq_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 500;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned SETTLE_CYCLES  = 50;
  localparam int unsigned HOLD_CYCLES    = 300;

  // One result word as the queue reports it.
  typedef struct packed {
    bpq_status_e              status;
    logic signed [ELEM_W-1:0] element;
    logic        [PRIO_W-1:0] top_prio;
    logic        [OCNT_W-1:0] count;
  } queue_reply_t;

  // One row of the scripted sequence. Where fixed is set, the reply is typed
  // in by hand; elsewhere the behavioral queue supplies it.
  typedef struct packed {
    logic                     kind;
    logic signed [ELEM_W-1:0] element;
    logic        [PRIO_W-1:0] prio;
    logic                     fixed;
    queue_reply_t             reply;
  } script_row_t;

  localparam queue_reply_t NO_REPLY = '{ST_OK, 32'sd0, 8'd0, 4'd0};

  localparam script_row_t SCRIPT [19] = '{
    // A delete on an empty queue is refused.
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}},
    // Fill the queue with extreme elements and priorities, with ties at 255.
    '{KIND_INSERT, 32'h8000_0000, 8'd0,   1'b1, '{ST_OK, 32'sd0, 8'd0, 4'd1}},
    '{KIND_INSERT, 32'h7fff_ffff, 8'd255, 1'b1, '{ST_OK, 32'sd0, 8'd255, 4'd2}},
    '{KIND_INSERT, 32'hffff_ffff, 8'd255, 1'b0, NO_REPLY},
    '{KIND_INSERT, 32'h0000_0000, 8'd1,   1'b0, NO_REPLY},
    '{KIND_INSERT, 32'h5555_5555, 8'd128, 1'b0, NO_REPLY},
    '{KIND_INSERT, 32'haaaa_aaaa, 8'd127, 1'b0, NO_REPLY},
    '{KIND_INSERT, 32'h0000_0001, 8'd255, 1'b0, NO_REPLY},
    '{KIND_INSERT, 32'hffff_fffe, 8'd0,   1'b0, NO_REPLY},
    // The queue is full now, so this insert is refused and changes nothing.
    '{KIND_INSERT, 32'h1234_5678, 8'd200, 1'b1, '{ST_FULL, 32'sd0, 8'd255, 4'd8}},
    // Drain it. The first delete carries junk operands, which must be ignored,
    // and must take the last of the three entries tied at 255.
    '{KIND_DELETE, 32'hffff_ffff, 8'd255, 1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
    // Empty again.
    '{KIND_DELETE, 32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 4'd0}}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     kind_i;
  logic signed [ELEM_W-1:0] element_in_i;
  logic        [PRIO_W-1:0] priority_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic        [STAT_W-1:0] status_o;
  logic signed [ELEM_W-1:0] element_out_o;
  logic        [PRIO_W-1:0] top_priority_o;
  logic        [OCNT_W-1:0] count_o;

  // Behavioral copy of the queue: entries in insertion order plus a count.
  logic signed [ELEM_W-1:0] model_values [DEPTH];
  logic        [PRIO_W-1:0] model_prios  [DEPTH];
  int unsigned              model_stored;

  // Replies the queue owes us, oldest first.
  queue_reply_t reply_q [$];

  int unsigned mismatches = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;

  bounded_priority_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .element_in_i   (element_in_i),
    .priority_in_i  (priority_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .element_out_o  (element_out_o),
    .top_priority_o (top_priority_o),
    .count_o        (count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Index of the highest priority entry; the last one wins among equals.
  function automatic int unsigned highest_entry();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < model_stored; i++) begin
      if (model_prios[i] >= model_prios[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Applies one accepted word to the behavioral queue and returns the reply
  // the block should give for it.
  task automatic apply_word(input logic kind, input logic signed [ELEM_W-1:0] element,
                            input logic [PRIO_W-1:0] prio, output queue_reply_t reply);
    int unsigned top;
    reply = NO_REPLY;
    if (kind == KIND_INSERT) begin
      if (model_stored >= DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        model_values[model_stored] = element;
        model_prios[model_stored]  = prio;
        model_stored++;
      end
    end else if (model_stored == 0) begin
      reply.status = ST_EMPTY;
    end else begin
      top = highest_entry();
      reply.element = model_values[top];
      // Close the gap left by the removed entry.
      for (int unsigned j = top; j + 1 < model_stored; j++) begin
        model_values[j] = model_values[j + 1];
        model_prios[j]  = model_prios[j + 1];
      end
      model_stored--;
    end
    reply.top_prio = (model_stored == 0) ? '0 : model_prios[highest_entry()];
    reply.count    = model_stored[OCNT_W-1:0];
  endtask

  // Offers one word, with random idle cycles ahead of it, and waits until the
  // queue takes it. Valid stays high from one word to the next when no idle
  // cycle falls between them.
  task automatic send_word(input logic kind, input logic signed [ELEM_W-1:0] element,
                           input logic [PRIO_W-1:0] prio, input logic fixed,
                           input queue_reply_t typed_reply);
    queue_reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    element_in_i  <= element;
    priority_in_i <= prio;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    apply_word(kind, element, prio, predicted);
    reply_q.push_back(fixed ? typed_reply : predicted);
  endtask

  // Receiver side: random stalls, plus one long hold-off that lets the queue
  // back up until it stalls its own input. The hold-off is counted here.
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Every result word taken is compared with the oldest reply owed.
  always @(posedge clk_i) begin : check_results
    queue_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        flag_mismatch($sformatf("result word with nothing expected, status %0d", status_o));
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        end
        if (element_out_o !== want.element) begin
          flag_mismatch($sformatf("element %0d, expected %0d", element_out_o, want.element));
        end
        if (top_priority_o !== want.top_prio) begin
          flag_mismatch($sformatf("top priority %0d, expected %0d",
                                  top_priority_o, want.top_prio));
        end
        if (count_o !== want.count) begin
          flag_mismatch($sformatf("count %0d, expected %0d", count_o, want.count));
        end
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    int unsigned              insert_pct;
    logic                     kind;
    logic signed [ELEM_W-1:0] element;
    logic        [PRIO_W-1:0] prio;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_INSERT;
    element_in_i   = '0;
    priority_in_i  = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 25;
    recv_stall_pct = 71;
    model_stored   = 0;
    insert_pct     = 50;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted part: empty and full queues, extreme values and priority ties.
    foreach (SCRIPT[r]) begin
      send_word(SCRIPT[r].kind, SCRIPT[r].element, SCRIPT[r].prio,
                SCRIPT[r].fixed, SCRIPT[r].reply);
    end

    // Random part. The mix of inserts and deletes drifts in runs of words so
    // that the queue regularly climbs to full and drains to empty.
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 0) begin
        // Long hold-off right away; the sender keeps offering meanwhile.
        hold_req = 1'b1;
      end
      if (n == RANDOM_WORDS / 3) begin
        send_idle_pct  = 71;
        recv_stall_pct = 25;
      end
      if (n == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (n % 24 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      kind    = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
      element = $urandom;
      // Few distinct priorities most of the time, so that ties are common.
      case ($urandom_range(3))
        0, 1:    prio = PRIO_W'($urandom_range(3));
        2:       prio = PRIO_W'($urandom_range(255));
        default: prio = $urandom_range(1) ? 8'd255 : 8'd0;
      endcase
      send_word(kind, element, prio, 1'b0, NO_REPLY);
    end
    in_valid_i <= 1'b0;

    // Wait for every owed reply, then a little longer for strays.
    while (reply_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #(20 * TIMEOUT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_mem.sv
hw/rtl/bpq_seq.sv
hw/rtl/bounded_priority_queue_top.sv
tb/tb_top.sv
